### design/hlm_pkg.sv
// Shared types, sizes and byte helpers for the header label matcher.
// Used by header_label_matcher, hlm_cell and the testbench; depends on nothing else.
package hlm_pkg;

  localparam int MaxLabels   = 16;
  localparam int MaxLabelLen = 64;
  localparam int WinDepth    = MaxLabelLen + 2;
  localparam int HposMax     = (MaxLabelLen < 64) ? 127 : (2 * MaxLabelLen - 1);

  localparam int LblIdxW = (MaxLabels > 1) ? $clog2(MaxLabels) : 1;
  localparam int CountW  = $clog2(MaxLabels + 1);
  localparam int PosW    = (MaxLabelLen > 1) ? $clog2(MaxLabelLen) : 1;
  localparam int LenW    = $clog2(MaxLabelLen + 1);
  localparam int HposW   = $clog2(HposMax + 1);
  localparam int CmpW    = HposW + 1;
  localparam int AddrW   = (MaxLabels * MaxLabelLen > 1) ? $clog2(MaxLabels * MaxLabelLen) : 1;

  localparam logic [7:0] SemiChar = 8'h3b;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_HDR   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_EXACT  = 2'd0,
    MODE_SUBSTR = 2'd1,
    MODE_WORD   = 2'd2,
    MODE_FIELD  = 2'd3
  } mode_e;

  typedef struct packed {
    logic win_shift;
    logic win_clear;
    logic scan_load;
    logic scan_shift;
  } hlm_cell_ctl_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) ? (c - 8'd32) : c;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic side_ok(input logic at_edge, input logic [7:0] c,
                                   input logic [1:0] mode);
    logic ok;
    if (at_edge) ok = 1'b1;
    else if (mode == MODE_WORD) ok = !is_alnum(c);
    else ok = (c == SemiChar);
    return ok;
  endfunction

  function automatic logic [AddrW-1:0] lbl_addr(input logic [LblIdxW-1:0] idx,
                                                input logic [PosW-1:0] pos);
    return AddrW'(idx) * AddrW'(MaxLabelLen) + AddrW'(pos);
  endfunction

endpackage

### design/header_label_matcher.sv
// Top level of the header label matcher: control, label table, window chain.
// Depends on hlm_pkg, hlm_ram and hlm_cell.
//
// Labels are loaded byte by byte into a label RAM (16 labels of up to 64
// bytes); a clear request empties the table. Header bytes shift into a chain
// of 66 byte cells that holds the most recent header window. For each header
// byte the controller walks the stored labels one after another: the window
// is copied into the scan side of the cells, and the label is read from the
// RAM last byte first, one byte per cycle, while the scan copy advances one
// cell per cycle, so that every label byte meets the window bytes it lines
// up with at fixed taps. Case-folded and exact comparisons for an occurrence
// ending at this byte and at the previous byte are collected in that one
// pass, together with the bytes just outside the occurrence. The controller
// takes no new item while it walks the labels for a header byte, a walk
// bounded by the single read port of the label RAM; label loads and clears
// are taken without leaving the idle state. On the header's last byte one
// transaction carries matched and table_overflow; it waits in an output
// register while further items are accepted, and only a following last
// header byte stalls behind it.
module header_label_matcher import hlm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       match_mode_we_i,
  input  logic [1:0] match_mode_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       matched_o,
  output logic       table_overflow_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_RUN, ST_TAIL, ST_EVAL, ST_FINISH
  } state_e;

  state_e state_q;

  logic [1:0]        mode_q;
  logic [LenW-1:0]   len_q [MaxLabels];
  logic [MaxLabels-1:0] alive_q;
  logic [CountW-1:0] count_q;
  logic [LenW-1:0]   lpos_q;
  logic [HposW-1:0]  hpos_q;
  logic              found_q;
  logic              ovf_q;
  logic              hdr_last_q;
  logic [CountW-1:0] k_q;
  logic [PosW-1:0]   j_q;

  // compare pipeline, registered alongside the RAM read data
  logic              cmp_v_q;
  logic              cmp_last_q;
  logic [PosW-1:0]   cmp_i_q;
  logic              mn0_q, ms0_q, ms1_q, ex_q;
  logic [7:0]        side0_q, side1_q;

  logic              out_valid_q, matched_q, tovf_q;

  // window chain
  logic [7:0]    win   [WinDepth];
  logic [7:0]    scan  [WinDepth];
  hlm_cell_ctl_t cell_ctl;

  logic              in_fire;
  logic [LblIdxW-1:0] k_idx;
  logic [LenW-1:0]   n_cur;
  logic [PosW-1:0]   i_run;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [7:0]        rdata;
  logic              can_emit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign k_idx      = k_q[LblIdxW-1:0];
  assign n_cur      = len_q[k_idx];
  assign i_run      = PosW'(n_cur - LenW'(1) - LenW'(j_q));
  assign can_emit   = !out_valid_q || out_ready_i;

  assign cell_ctl.win_shift  = in_fire && (req_type_i == REQ_HDR);
  assign cell_ctl.win_clear  = (state_q == ST_FINISH) && hdr_last_q && can_emit;
  assign cell_ctl.scan_load  = (state_q == ST_LOAD) && (k_q != count_q) &&
                               (n_cur != '0);
  assign cell_ctl.scan_shift = cmp_v_q;

  for (genvar c = 0; c < WinDepth; c++) begin : g_cell
    logic [7:0] win_in;
    logic [7:0] scan_in;
    if (c == 0) begin : g_head
      assign win_in = data_byte_i;
    end else begin : g_body
      assign win_in = win[c-1];
    end
    if (c == WinDepth - 1) begin : g_tail
      assign scan_in = 8'd0;
    end else begin : g_mid
      assign scan_in = scan[c+1];
    end
    hlm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl),
      .win_i  (win_in),
      .scan_i (scan_in),
      .win_o  (win[c]),
      .scan_o (scan[c])
    );
  end

  // label bytes: write on load, read last byte first during the scan
  assign ram_we = in_fire && (req_type_i == REQ_LOAD) &&
                  (count_q < CountW'(MaxLabels)) && (lpos_q < LenW'(MaxLabelLen));
  assign ram_waddr = lbl_addr(count_q[LblIdxW-1:0], lpos_q[PosW-1:0]);

  hlm_ram #(
    .Width (8),
    .Depth (MaxLabels * MaxLabelLen)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data_byte_i),
    .raddr_i (lbl_addr(k_idx, i_run)),
    .rdata_o (rdata)
  );

  // per-label decision, taken once the scan has drained
  logic [CmpW-1:0] p_w, p1_w, n_w;
  logic            alive_new, hit_sub, hit_prev, hit_edge, hit_exact, mode_wf;
  logic [7:0]      b_cur;

  always_comb begin
    p_w       = CmpW'(hpos_q);
    p1_w      = p_w + CmpW'(1);
    n_w       = CmpW'(n_cur);
    b_cur     = win[0];
    mode_wf   = (mode_q == MODE_WORD) || (mode_q == MODE_FIELD);
    alive_new = alive_q[k_idx] && ex_q;
    hit_sub   = (mode_q == MODE_SUBSTR) && (p1_w >= n_w) && mn0_q;
    hit_prev  = mode_wf && (p_w >= n_w) && ms1_q &&
                side_ok(p_w == n_w, side1_q, mode_q) && side_ok(1'b0, b_cur, mode_q);
    hit_edge  = mode_wf && hdr_last_q && (p1_w >= n_w) && ms0_q &&
                side_ok(p1_w == n_w, side0_q, mode_q);
    hit_exact = (mode_q == MODE_EXACT) && hdr_last_q && alive_new && (p1_w == n_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_EXACT;
    end else if (match_mode_we_i) begin
      mode_q <= match_mode_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int e = 0; e < MaxLabels; e++) len_q[e] <= '0;
      alive_q     <= '1;
      count_q     <= '0;
      lpos_q      <= '0;
      hpos_q      <= '0;
      found_q     <= 1'b0;
      ovf_q       <= 1'b0;
      hdr_last_q  <= 1'b0;
      k_q         <= '0;
      j_q         <= '0;
      cmp_v_q     <= 1'b0;
      cmp_last_q  <= 1'b0;
      cmp_i_q     <= '0;
      mn0_q       <= 1'b0;
      ms0_q       <= 1'b0;
      ms1_q       <= 1'b0;
      ex_q        <= 1'b0;
      side0_q     <= 8'd0;
      side1_q     <= 8'd0;
      out_valid_q <= 1'b0;
      matched_q   <= 1'b0;
      tovf_q      <= 1'b0;
    end else begin
      // drop the result once taken; a new one below overrides
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      cmp_v_q    <= (state_q == ST_RUN);
      cmp_last_q <= (state_q == ST_RUN) && (LenW'(j_q) == n_cur - LenW'(1));
      cmp_i_q    <= i_run;

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            unique case (req_type_i)
              REQ_CLEAR: begin
                for (int e = 0; e < MaxLabels; e++) len_q[e] <= '0;
                count_q <= '0;
                lpos_q  <= '0;
                ovf_q   <= 1'b0;
              end
              REQ_LOAD: begin
                if (count_q >= CountW'(MaxLabels)) begin
                  ovf_q <= 1'b1;
                  if (last_i) lpos_q <= '0;
                end else begin
                  if (lpos_q >= LenW'(MaxLabelLen)) ovf_q <= 1'b1;
                  if (last_i) begin
                    len_q[count_q[LblIdxW-1:0]] <= (lpos_q < LenW'(MaxLabelLen)) ?
                                                   lpos_q + LenW'(1) : lpos_q;
                    alive_q[count_q[LblIdxW-1:0]] <= (hpos_q == '0);
                    count_q <= count_q + CountW'(1);
                    lpos_q  <= '0;
                  end else if (lpos_q < LenW'(MaxLabelLen)) begin
                    lpos_q <= lpos_q + LenW'(1);
                  end
                end
              end
              REQ_HDR: begin
                hdr_last_q <= last_i;
                k_q        <= '0;
                state_q    <= ST_LOAD;
              end
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          if (k_q == count_q) begin
            state_q <= ST_FINISH;
          end else if (n_cur == '0) begin
            k_q <= k_q + CountW'(1);
          end else begin
            j_q     <= '0;
            mn0_q   <= 1'b1;
            ms0_q   <= 1'b1;
            ms1_q   <= 1'b1;
            ex_q    <= 1'b0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (LenW'(j_q) == n_cur - LenW'(1)) state_q <= ST_TAIL;
          else j_q <= j_q + PosW'(1);
        end
        ST_TAIL: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          alive_q[k_idx] <= alive_new;
          if (hit_sub || hit_prev || hit_edge || hit_exact) found_q <= 1'b1;
          k_q     <= k_q + CountW'(1);
          state_q <= ST_LOAD;
        end
        ST_FINISH: begin
          if (!hdr_last_q) begin
            hpos_q  <= (hpos_q == HposW'(HposMax)) ? hpos_q : hpos_q + HposW'(1);
            state_q <= ST_IDLE;
          end else if (can_emit) begin
            out_valid_q <= 1'b1;
            matched_q   <= found_q;
            tovf_q      <= ovf_q;
            found_q     <= 1'b0;
            alive_q     <= '1;
            hpos_q      <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // hold a label byte against the window taps, then advance the scan
      if (cmp_v_q) begin
        if (fold(rdata) != fold(scan[0])) mn0_q <= 1'b0;
        if (rdata != scan[0]) ms0_q <= 1'b0;
        if (rdata != scan[1]) ms1_q <= 1'b0;
        if ((CmpW'(cmp_i_q) == CmpW'(hpos_q)) && (fold(rdata) == fold(win[0]))) begin
          ex_q <= 1'b1;
        end
        if (cmp_last_q) begin
          side0_q <= scan[1];
          side1_q <= scan[2];
        end
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign matched_o        = matched_q;
  assign table_overflow_o = tovf_q;

endmodule

### design/hlm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package needed.
module hlm_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/hlm_cell.sv
// One byte cell of the header window chain plus its scan copy.
// Depends on hlm_pkg for the control struct.
module hlm_cell import hlm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hlm_cell_ctl_t ctl_i,
  input  logic [7:0]    win_i,
  input  logic [7:0]    scan_i,
  output logic [7:0]    win_o,
  output logic [7:0]    scan_o
);

  logic [7:0] win_q;
  logic [7:0] scan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 8'd0;
    end else if (ctl_i.win_clear) begin
      win_q <= 8'd0;
    end else if (ctl_i.win_shift) begin
      win_q <= win_i;
    end
  end

  // scan copy: load from own window byte, advance toward cell zero
  always_ff @(posedge clk_i) begin
    if (ctl_i.scan_load) begin
      scan_q <= win_q;
    end else if (ctl_i.scan_shift) begin
      scan_q <= scan_i;
    end
  end

  assign win_o  = win_q;
  assign scan_o = scan_q;

endmodule

### tb/tb_header_label_matcher.sv
// Self-checking testbench for header_label_matcher: loads label tables, streams headers
// under all four match modes, and checks every match verdict against a local predictor.
// Depends on hlm_pkg and the header_label_matcher RTL.
module tb_header_label_matcher;
  timeunit 1ns;
  timeprecision 1ps;
  import hlm_pkg::*;

  localparam int SettleCycles = 1200;     // outlasts the scan of a header byte over a full table of longest labels
  localparam int CycleLimit   = 10000000;
  localparam int TargetItems  = 1350;
  localparam int HoldCycles   = 3000;

  typedef struct {
    logic [1:0] req;
    logic [7:0] data;
    logic       lst;
  } hdr_item_t;

  typedef struct {
    logic matched;
    logic ovf;
  } verdict_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       match_mode_we_i = 1'b0;
  logic [1:0] match_mode_i = MODE_EXACT;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] req_type_i = REQ_NONE;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       matched_o;
  logic       table_overflow_o;

  header_label_matcher dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .match_mode_we_i (match_mode_we_i),
    .match_mode_i    (match_mode_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .data_byte_i     (data_byte_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .matched_o       (matched_o),
    .table_overflow_o(table_overflow_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Transactions waiting to be driven, and verdicts waiting to come out.
  hdr_item_t byte_feed[$];
  verdict_t  verdict_q[$];

  int  errors = 0;
  int  n_items = 0;
  int  n_acc = 0;
  int  n_res = 0;
  int  n_hits = 0;
  int  n_ovf = 0;
  int  cycles = 0;
  bit  calm = 1'b0;    // no random gaps on either side while set

  // ---------------------------------------------------------------------------
  // Predictor state: label table, header window and per-label exact trackers.
  // ---------------------------------------------------------------------------
  mode_e      cur_mode = MODE_EXACT;
  logic [7:0] lbl_mem[MaxLabels][MaxLabelLen];
  int         lbl_len[MaxLabels];
  int         lbl_cnt;
  int         ld_pos;
  logic [7:0] win[WinDepth];
  int         hpos;
  bit         alive[MaxLabels];
  bit         found;
  bit         ovf_flag;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= "a" && c <= "z") return c ^ 8'h20;
    return c;
  endfunction

  function automatic bit word_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Does label k of length n sit in the window, its last byte at slot off?
  function automatic bit occurs(input int k, input int n, input int off, input bit nocase);
    logic [7:0] a, w;
    for (int i = 0; i < n; i++) begin
      a = lbl_mem[k][i];
      w = win[off + n - 1 - i];
      if (nocase ? (upcase(a) != upcase(w)) : (a != w)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit bound_ok(input bit at_edge, input logic [7:0] c, input mode_e md);
    if (at_edge) return 1'b1;
    if (md == MODE_WORD) return !word_char(c);
    return c == ";";
  endfunction

  function automatic void reset_header();
    for (int i = 0; i < WinDepth; i++) win[i] = 8'h00;
    hpos = 0;
    found = 1'b0;
    for (int k = 0; k < MaxLabels; k++) alive[k] = 1'b1;
  endfunction

  // Advance the predictor by one accepted transaction; queue a verdict on a last header byte.
  function automatic void advance_matcher(input logic [1:0] req, input logic [7:0] b,
                                          input logic lst);
    int       p, n;
    bit       hit;
    verdict_t v;
    if (req == REQ_CLEAR) begin
      for (int k = 0; k < MaxLabels; k++) lbl_len[k] = 0;
      lbl_cnt = 0;
      ld_pos = 0;
      ovf_flag = 1'b0;
    end else if (req == REQ_LOAD) begin
      if (lbl_cnt >= MaxLabels) begin
        // table full: drop the byte
        ovf_flag = 1'b1;
        if (lst) ld_pos = 0;
      end else begin
        if (ld_pos < MaxLabelLen) begin
          lbl_mem[lbl_cnt][ld_pos] = b;
          ld_pos++;
        end else begin
          ovf_flag = 1'b1;
        end
        if (lst) begin
          lbl_len[lbl_cnt] = ld_pos;
          alive[lbl_cnt] = (hpos == 0);
          lbl_cnt++;
          ld_pos = 0;
        end
      end
    end else if (req == REQ_HDR) begin
      p = hpos;
      for (int i = WinDepth - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = b;
      hit = 1'b0;
      for (int k = 0; k < lbl_cnt; k++) begin
        n = lbl_len[k];
        if (n == 0) continue;
        if (p >= n) alive[k] = 1'b0;
        else if (upcase(b) != upcase(lbl_mem[k][p])) alive[k] = 1'b0;
        if (cur_mode == MODE_SUBSTR) begin
          if (p + 1 >= n && occurs(k, n, 0, 1'b1)) found = 1'b1;
        end else if (cur_mode == MODE_WORD || cur_mode == MODE_FIELD) begin
          // occurrence that ended one byte ago, closed by this byte
          if (p >= n && occurs(k, n, 1, 1'b0) && bound_ok(p == n, win[n+1], cur_mode) &&
              bound_ok(1'b0, b, cur_mode))
            found = 1'b1;
          // occurrence ending here, closed by the header edge
          if (lst && p + 1 >= n && occurs(k, n, 0, 1'b0) &&
              bound_ok(p + 1 == n, win[n], cur_mode))
            found = 1'b1;
        end else if (lst && alive[k] && p + 1 == n) begin
          hit = 1'b1;
        end
      end
      hpos = (p + 1 > HposMax) ? HposMax : p + 1;
      if (lst) begin
        v.matched = hit || found;
        v.ovf = ovf_flag;
        verdict_q.push_back(v);
        reset_header();
      end
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: hold valid and payload until the transaction is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive
    int        gap;
    bit        busy;
    hdr_item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_type_i <= REQ_NONE;
      data_byte_i <= 8'h00;
      last_i <= 1'b0;
      gap = 0;
      lbl_cnt = 0;
      ld_pos = 0;
      ovf_flag = 1'b0;
      for (int k = 0; k < MaxLabels; k++) lbl_len[k] = 0;
      reset_header();
    end else begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        advance_matcher(req_type_i, data_byte_i, last_i);
        n_acc++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap > 0) begin
          gap--;
          in_valid_i <= 1'b0;
        end else if (byte_feed.size() > 0) begin
          it = byte_feed.pop_front();
          req_type_i <= it.req;
          data_byte_i <= it.data;
          last_i <= it.lst;
          in_valid_i <= 1'b1;
          gap = gap_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver readiness: random stalls, plus one long hold-off once traffic is
  // well under way so results back up and the input side stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : backpressure
    int stall_left;
    int hold_left;
    bit hold_done;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && n_acc >= 600) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = gap_len();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each verdict with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    verdict_t v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_res++;
      if (matched_o) n_hits++;
      if (table_overflow_o) n_ovf++;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result matched=%0b table_overflow=%0b",
                 $time, matched_o, table_overflow_o);
      end else begin
        v = verdict_q.pop_front();
        if (matched_o !== v.matched) begin
          errors++;
          $display("%0t: matched expected %0b actual %0b", $time, v.matched, matched_o);
        end
        if (table_overflow_o !== v.ovf) begin
          errors++;
          $display("%0t: table_overflow expected %0b actual %0b",
                   $time, v.ovf, table_overflow_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d verdicts outstanding", $time, verdict_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation. The generator keeps its own copy of the labels it
  // loaded so it can plant them inside headers.
  // ---------------------------------------------------------------------------
  mode_e      gen_mode = MODE_EXACT;
  logic [7:0] gen_lbl[MaxLabels][MaxLabelLen];
  int         gen_len[MaxLabels];
  int         gen_n = 0;
  string      field_pfx = "name=";

  task automatic push_item(input logic [1:0] req, input logic [7:0] b, input logic lst);
    hdr_item_t it;
    it.req = req;
    it.data = b;
    it.lst = lst;
    byte_feed.push_back(it);
    n_items++;
  endtask

  // Drain everything, then let a possible non-last header byte finish its scan.
  task automatic wait_idle();
    while (byte_feed.size() != 0 || in_valid_i || verdict_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_mode(input mode_e m);
    @(posedge clk_i);
    match_mode_we_i <= 1'b1;
    match_mode_i <= m;
    cur_mode = m;
    gen_mode = m;
    @(posedge clk_i);
    match_mode_we_i <= 1'b0;
  endtask

  // Small alphabet so labels collide often, with the odd arbitrary byte.
  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5)
      return upcase(8'("a" + $urandom_range(0, 2))) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
    if (r < 7) return 8'("0" + $urandom_range(0, 2));
    if (r < 8) return ($urandom_range(0, 1)) ? ";" : " ";
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] sep_char();
    if (gen_mode == MODE_FIELD) return ($urandom_range(0, 9) < 9) ? ";" : rand_char();
    if (gen_mode == MODE_WORD) begin
      case ($urandom_range(0, 3))
        0: return " ";
        1: return ".";
        2: return 8'h00;
        default: return 8'h80 | 8'($urandom_range(0, 127));
      endcase
    end
    return rand_char();
  endfunction

  function automatic logic [7:0] maybe_flip(input logic [7:0] c);
    if (word_char(c) && c > "9" && $urandom_range(0, 1)) return c ^ 8'h20;
    return c;
  endfunction

  task automatic load_label(input int len);
    logic [7:0] c;
    int         idx;
    idx = gen_n;
    for (int i = 0; i < len; i++) begin
      c = (gen_mode == MODE_FIELD && i < 5) ? field_pfx[i] : rand_char();
      if (idx < MaxLabels && i < MaxLabelLen) gen_lbl[idx][i] = c;
      push_item(REQ_LOAD, c, i == len - 1);
    end
    if (idx < MaxLabels) begin
      gen_len[idx] = (len > MaxLabelLen) ? MaxLabelLen : len;
      gen_n++;
    end
  endtask

  task automatic send_header();
    logic [7:0] hq[$];
    int         k, plen;
    bit         hit, nocase;
    hit = $urandom_range(0, 1) && gen_n > 0;
    nocase = (gen_mode == MODE_EXACT || gen_mode == MODE_SUBSTR);
    k = (gen_n > 0) ? $urandom_range(0, gen_n - 1) : 0;
    // now and then a header long enough to saturate the position counter
    if ($urandom_range(0, 24) == 0) repeat (130) hq.push_back(rand_char());
    if (gen_mode == MODE_EXACT) begin
      if (hit) for (int i = 0; i < gen_len[k]; i++) hq.push_back(maybe_flip(gen_lbl[k][i]));
      else repeat ($urandom_range(1, 10)) hq.push_back(rand_char());
    end else begin
      plen = $urandom_range(0, 5);
      repeat (plen) hq.push_back(rand_char());
      if (hq.size() > 0) hq.push_back(sep_char());
      if (hit) begin
        for (int i = 0; i < gen_len[k]; i++)
          hq.push_back(nocase ? maybe_flip(gen_lbl[k][i]) : gen_lbl[k][i]);
      end else begin
        repeat ($urandom_range(1, 8)) hq.push_back(rand_char());
      end
      if ($urandom_range(0, 1)) begin
        hq.push_back(sep_char());
        repeat ($urandom_range(0, 4)) hq.push_back(rand_char());
      end
    end
    for (int i = 0; i < hq.size(); i++) begin
      // label finished or table cleared while a header is in progress
      if (i == 1 && $urandom_range(0, 14) == 0) load_label($urandom_range(1, 3));
      if (i == 1 && $urandom_range(0, 29) == 0) begin
        push_item(REQ_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        gen_n = 0;
      end
      push_item(REQ_HDR, hq[i], i == hq.size() - 1);
    end
  endtask

  initial begin : stimulus
    int    ph, nl, nh;
    mode_e md;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, case-insensitive exact hit, ignored request,
    // extreme bytes, single-byte label, and a miss after a clear.
    push_item(REQ_HDR, 8'h00, 1'b1);
    push_item(REQ_LOAD, "A", 1'b0);
    push_item(REQ_LOAD, "b", 1'b1);
    push_item(REQ_HDR, "a", 1'b0);
    push_item(REQ_HDR, "B", 1'b1);
    push_item(REQ_NONE, 8'hff, 1'b1);
    push_item(REQ_HDR, 8'hff, 1'b1);
    push_item(REQ_LOAD, "z", 1'b1);
    push_item(REQ_HDR, "Z", 1'b1);
    push_item(REQ_HDR, "a", 1'b0);
    push_item(REQ_HDR, "b", 1'b0);
    push_item(REQ_HDR, "z", 1'b1);
    push_item(REQ_LOAD, 8'h80, 1'b1);
    push_item(REQ_HDR, 8'h80, 1'b1);
    push_item(REQ_CLEAR, 8'h5a, 1'b0);
    push_item(REQ_HDR, "a", 1'b0);
    push_item(REQ_HDR, "b", 1'b1);

    ph = 0;
    while (n_items < TargetItems) begin
      md = (ph < 4) ? mode_e'(ph) : mode_e'($urandom_range(0, 3));
      wait_idle();
      apply_mode(md);
      calm = (ph % 5 == 2);
      if (ph == 1) begin
        // overfill the table; the first label has the maximum length, the next two are too long to fit
        push_item(REQ_CLEAR, 8'h00, 1'b0);
        gen_n = 0;
        for (int j = 0; j < MaxLabels + 2; j++)
          load_label((j < 3) ? MaxLabelLen + 3 * j : $urandom_range(1, 6));
        nh = 3;
      end else begin
        if ($urandom_range(0, 4) != 0 || gen_n >= MaxLabels) begin
          push_item(REQ_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          gen_n = 0;
        end
        nl = $urandom_range(1, 5);
        for (int j = 0; j < nl; j++) begin
          if ($urandom_range(0, 7) == 0) load_label($urandom_range(40, MaxLabelLen));
          else if (gen_mode == MODE_FIELD) load_label($urandom_range(6, 10));
          else load_label($urandom_range(1, 8));
        end
        nh = $urandom_range(4, 10);
      end
      for (int j = 0; j < nh; j++) begin
        if ($urandom_range(0, 14) == 0)
          push_item(REQ_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_header();
      end
      // leave a header open across the next mode change now and then
      if ($urandom_range(0, 7) == 0) push_item(REQ_HDR, rand_char(), 1'b0);
      ph++;
    end

    wait_idle();
    $display("Drove %0d transactions over %0d phases in all four modes.", n_acc, ph);
    $display("Checked %0d verdicts: %0d matches, %0d with table overflow.",
             n_res, n_hits, n_ovf);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
